/* rtl/core/lcdnw_pkg.sv */
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types and constants for the LCD number writer pipeline.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_CMD   = 2'd0;
  localparam op_t OP_CHAR  = 2'd1;
  localparam op_t OP_PRINT = 2'd2;
  localparam op_t OP_NONE  = 2'd3;

  localparam int OPERAND_W = 17;

  localparam logic [7:0] CURSOR_CMD = 8'h8A;
  // ASCII '0' is 0x30: a digit only fills the low nibble
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  // floor(x / 10) == (x * DIV10_MULT) >> DIV10_SHIFT for x < 2^22
  localparam logic [19:0] DIV10_MULT  = 20'hCCCCD;
  localparam int          DIV10_SHIFT = 23;
  localparam int          PROD_W      = OPERAND_W + 20;

  typedef struct packed {
    op_t                  opcode;
    logic [7:0]           byte_val;
    logic [OPERAND_W-1:0] quot;
  } stage_t;

endpackage

/* rtl/core/lcd_number_writer.sv */
// ----------------------------------------------------------------------------
// lcd_number_writer
// Turns command, character and print-number requests into LCD bus writes.
// ----------------------------------------------------------------------------
// Path: a request passes the input register, one stage per digit, the holder
//   and the output registers before its first bus write.
// Throughput: one byte request per cycle while busy is low; a print request
//   occupies the output holder for a cursor command and DIGIT_COUNT digit writes, one bus write per cycle.
// The receiver cannot stall; busy only reflects the holder draining.
// Reset (rst, synchronous): empties every stage and drops strobe.
// ----------------------------------------------------------------------------
module lcd_number_writer import lcdnw_pkg::*; #(
  parameter int DIGIT_COUNT = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode,
  input  logic [OPERAND_W-1:0] operand,
  output logic                 strobe,
  output logic                 register_select,
  output logic [7:0]           bus_byte,
  output logic                 last
);

  localparam int DW = DIGIT_COUNT * 4;

  // stage 0 is the input register; stages 1..DIGIT_COUNT each add a digit
  logic            st_valid  [0:DIGIT_COUNT];
  logic            st_ready  [0:DIGIT_COUNT];
  stage_t          st_data   [0:DIGIT_COUNT];
  logic [DW-1:0]   st_digits [0:DIGIT_COUNT];

  // input register
  logic   req_valid;
  stage_t req_data;

  logic ready0;

  // Each stage moves when it is empty or its successor takes its data; the ready
  // path is one OR per stage back from the serializer.
  assign ready0 = !req_valid || st_ready[0];
  assign busy   = !ready0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (ready0) begin
      // unused opcode is taken but dropped here: it makes no bus write
      req_valid <= start && (opcode != OP_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (ready0 && start) begin
      req_data.opcode   <= opcode;
      req_data.byte_val <= operand[7:0];
      req_data.quot     <= operand;
    end
  end

  assign st_valid[0]  = req_valid;
  assign st_data[0]   = req_data;
  assign st_digits[0] = '0;

  for (genvar k = 1; k <= DIGIT_COUNT; k++) begin : g_digit
    lcdnw_div_stage #(
      .DIGIT_COUNT (DIGIT_COUNT),
      .IDX         (k - 1)
    ) u_div (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (st_valid[k-1]),
      .in_ready   (st_ready[k-1]),
      .in_data    (st_data[k-1]),
      .in_digits  (st_digits[k-1]),
      .out_valid  (st_valid[k]),
      .out_ready  (st_ready[k]),
      .out_data   (st_data[k]),
      .out_digits (st_digits[k])
    );
  end

  // output holder: for a print request, cursor command, then digits least significant first
  lcdnw_serializer #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_ser (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (st_valid[DIGIT_COUNT]),
    .in_ready        (st_ready[DIGIT_COUNT]),
    .in_data         (st_data[DIGIT_COUNT]),
    .in_digits       (st_digits[DIGIT_COUNT]),
    .strobe          (strobe),
    .register_select (register_select),
    .bus_byte        (bus_byte),
    .last            (last)
  );

`ifndef ASSERT_OFF
  // a multi-write burst never has a gap
  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("burst broken before its last write");

  // the only non-final instruction write is the cursor command
  a_cursor_then_digit: assert property (@(posedge clk) disable iff (rst)
    strobe && !last && !register_select |-> bus_byte == CURSOR_CMD ##1 register_select)
    else $error("cursor command not followed by a digit");

  // non-final data writes are ASCII digits
  a_digit_ascii: assert property (@(posedge clk) disable iff (rst)
    strobe && !last && register_select |-> bus_byte[7:4] == ASCII_DIGIT_HI &&
      bus_byte[3:0] <= 4'd9)
    else $error("digit write out of range");

  // busy only when the input register holds a request
  a_busy_held: assert property (@(posedge clk) disable iff (rst)
    busy |-> req_valid)
    else $error("busy with an empty input stage");
`endif

endmodule

/* rtl/core/lcdnw_div_stage.sv */
// ----------------------------------------------------------------------------
// lcdnw_div_stage
// One pipeline stage: peels off one decimal digit by a reciprocal multiply.
// ----------------------------------------------------------------------------
module lcdnw_div_stage import lcdnw_pkg::*; #(
  parameter int DIGIT_COUNT = 5,
  parameter int IDX         = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  stage_t                   in_data,
  input  logic [DIGIT_COUNT*4-1:0] in_digits,
  output logic                     out_valid,
  input  logic                     out_ready,
  output stage_t                   out_data,
  output logic [DIGIT_COUNT*4-1:0] out_digits
);

  localparam int Q_W = PROD_W - DIV10_SHIFT;

  logic [PROD_W-1:0]          prod;
  logic [Q_W-1:0]             q;
  logic [OPERAND_W-1:0]       q_ext;
  logic [OPERAND_W-1:0]       rem;
  stage_t                     data_next;
  logic [DIGIT_COUNT*4-1:0]   digits_next;

  assign prod  = PROD_W'(in_data.quot) * PROD_W'(DIV10_MULT);
  assign q     = prod[PROD_W-1:DIV10_SHIFT];
  assign q_ext = OPERAND_W'(q);
  // remainder = x - 10*q, as shift-add
  assign rem   = in_data.quot - ((q_ext << 3) + (q_ext << 1));

  always_comb begin
    data_next               = in_data;
    data_next.quot          = q_ext;
    digits_next             = in_digits;
    digits_next[IDX*4 +: 4] = rem[3:0];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data   <= data_next;
      out_digits <= digits_next;
    end
  end

endmodule

/* rtl/core/lcdnw_serializer.sv */
// ----------------------------------------------------------------------------
// lcdnw_serializer
// Holds one converted request and sends its bus writes, one per cycle.
// ----------------------------------------------------------------------------
module lcdnw_serializer import lcdnw_pkg::*; #(
  parameter int DIGIT_COUNT = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  stage_t                   in_data,
  input  logic [DIGIT_COUNT*4-1:0] in_digits,
  output logic                     strobe,
  output logic                     register_select,
  output logic [7:0]               bus_byte,
  output logic                     last
);

  localparam int BEAT_W = $clog2(DIGIT_COUNT + 1);

  logic                     hold_valid;
  op_t                      opcode;
  logic [7:0]               byte_val;
  logic [DIGIT_COUNT*4-1:0] digits;
  logic [BEAT_W-1:0]        beat;

  logic       rs_next;
  logic [7:0] byte_next;
  logic       last_next;

  always_comb begin
    rs_next   = 1'b0;
    byte_next = byte_val;
    last_next = 1'b1;
    unique case (opcode)
      OP_CMD: begin
        rs_next = 1'b0;
      end
      OP_CHAR: begin
        rs_next = 1'b1;
      end
      OP_PRINT: begin
        if (beat == '0) begin
          rs_next   = 1'b0;
          byte_next = CURSOR_CMD;
          last_next = 1'b0;
        end else begin
          rs_next   = 1'b1;
          byte_next = {ASCII_DIGIT_HI, digits[3:0]};
          last_next = (beat == BEAT_W'(DIGIT_COUNT));
        end
      end
      default: begin
        rs_next = 1'b0;
      end
    endcase
  end

  // free when empty or on the final write of the held request
  assign in_ready = !hold_valid || last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= hold_valid;
      if (in_ready) begin
        hold_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid) begin
      register_select <= rs_next;
      bus_byte        <= byte_next;
      last            <= last_next;
      beat            <= beat + BEAT_W'(1);
      if (beat != '0) begin
        digits <= digits >> 4;
      end
    end
    if (in_ready && in_valid) begin
      opcode   <= in_data.opcode;
      byte_val <= in_data.byte_val;
      digits   <= in_digits;
      beat     <= '0;
    end
  end

endmodule
